FILE: hw/rtl/rbsm_pkg.sv
// Shared constants and types for the region box sum and mean block.
// Holds the configuration register codes; no dependencies.
package rbsm_pkg;

	localparam int CFG_INDEX_W = 3;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_MIDDLE_SIZE  = 3'd0;
	localparam cfg_index_t REG_INNER_SIZE   = 3'd1;
	localparam cfg_index_t REG_OUTER_BEGIN  = 3'd2;
	localparam cfg_index_t REG_MIDDLE_BEGIN = 3'd3;
	localparam cfg_index_t REG_INNER_BEGIN  = 3'd4;
	localparam cfg_index_t REG_OUTER_LIMIT  = 3'd5;
	localparam cfg_index_t REG_MIDDLE_LIMIT = 3'd6;
	localparam cfg_index_t REG_INNER_LIMIT  = 3'd7;

endpackage

FILE: hw/rtl/rbsm_fifo.sv
// Small register queue between the front and back parts.
// No package dependencies.
module rbsm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

FILE: hw/rtl/rbsm_front.sv
// Front part: configuration registers, raster index tracking and saturating sums.
// Depends on rbsm_pkg; pushes one record per array into the middle queue.
module rbsm_front #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int AXIS_WIDTH   = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  rbsm_pkg::cfg_index_t                  cfg_index,
	input  logic [AXIS_WIDTH:0]                   cfg_data,
	input  logic                                  accept,
	input  logic signed [SAMPLE_WIDTH-1:0]        original_sample,
	input  logic signed [SAMPLE_WIDTH-1:0]        decoded_sample,
	input  logic                                  last_element,
	output logic                                  rec_push,
	output logic [((SAMPLE_WIDTH + 3*AXIS_WIDTH > 63) ? 63 : SAMPLE_WIDTH + 3*AXIS_WIDTH)*2
		+ 3*AXIS_WIDTH:0]                         rec_data
);
	import rbsm_pkg::*;

	localparam int SUM_W   = (SAMPLE_WIDTH + 3*AXIS_WIDTH > 63) ? 63
		: SAMPLE_WIDTH + 3*AXIS_WIDTH;
	localparam int COUNT_W = 3*AXIS_WIDTH + 1;
	localparam int AW      = AXIS_WIDTH;

	logic [AW:0]   middle_size_q, inner_size_q;
	logic [AW-1:0] outer_begin_q, middle_begin_q, inner_begin_q;
	logic [AW:0]   outer_limit_q, middle_limit_q, inner_limit_q;

	logic [AW-1:0]             outer_q, middle_q, inner_q;
	logic signed [SUM_W-1:0]   orig_acc_q, dec_acc_q;
	logic [COUNT_W-1:0]        count_q;

	logic                      in_box;
	logic signed [SUM_W-1:0]   orig_next, dec_next;
	logic [COUNT_W-1:0]        count_next;
	logic [AW:0]               inner_ext, middle_ext;
	logic [AW:0]               inner_inc, middle_inc;

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0]        acc,
		input logic signed [SAMPLE_WIDTH-1:0] x
	);
		logic signed [SUM_W:0] r;
		r = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};
		if (r[SUM_W] != r[SUM_W-1]) begin
			return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		return r[SUM_W-1:0];
	endfunction

	function automatic logic [AW:0] extent(input logic [AW:0] size);
		if (size == '0) begin
			return (AW+1)'(1);
		end
		if (size > {1'b1, {AW{1'b0}}}) begin
			return {1'b1, {AW{1'b0}}};
		end
		return size;
	endfunction

	assign in_box = (outer_q >= outer_begin_q) && ({1'b0, outer_q} < outer_limit_q)
		&& (middle_q >= middle_begin_q) && ({1'b0, middle_q} < middle_limit_q)
		&& (inner_q >= inner_begin_q) && ({1'b0, inner_q} < inner_limit_q);

	always_comb begin
		orig_next  = orig_acc_q;
		dec_next   = dec_acc_q;
		count_next = count_q;
		if (in_box) begin
			orig_next = sat_add(orig_acc_q, original_sample);
			dec_next  = sat_add(dec_acc_q, decoded_sample);
			if (count_q != '1) begin
				count_next = count_q + 1'b1;
			end
		end
	end

	assign inner_ext  = extent(inner_size_q);
	assign middle_ext = extent(middle_size_q);
	assign inner_inc  = {1'b0, inner_q} + 1'b1;
	assign middle_inc = {1'b0, middle_q} + 1'b1;

	assign rec_push = accept && last_element;
	assign rec_data = {orig_next, dec_next, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			middle_size_q  <= (AW+1)'(1);
			inner_size_q   <= (AW+1)'(1);
			outer_begin_q  <= '0;
			middle_begin_q <= '0;
			inner_begin_q  <= '0;
			outer_limit_q  <= {1'b1, {AW{1'b0}}};
			middle_limit_q <= {1'b1, {AW{1'b0}}};
			inner_limit_q  <= {1'b1, {AW{1'b0}}};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIDDLE_SIZE:  middle_size_q  <= cfg_data;
				REG_INNER_SIZE:   inner_size_q   <= cfg_data;
				REG_OUTER_BEGIN:  outer_begin_q  <= cfg_data[AW-1:0];
				REG_MIDDLE_BEGIN: middle_begin_q <= cfg_data[AW-1:0];
				REG_INNER_BEGIN:  inner_begin_q  <= cfg_data[AW-1:0];
				REG_OUTER_LIMIT:  outer_limit_q  <= cfg_data;
				REG_MIDDLE_LIMIT: middle_limit_q <= cfg_data;
				REG_INNER_LIMIT:  inner_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q    <= '0;
			middle_q   <= '0;
			inner_q    <= '0;
			orig_acc_q <= '0;
			dec_acc_q  <= '0;
			count_q    <= '0;
		end else if (accept) begin
			if (last_element) begin
				outer_q    <= '0;
				middle_q   <= '0;
				inner_q    <= '0;
				orig_acc_q <= '0;
				dec_acc_q  <= '0;
				count_q    <= '0;
			end else begin
				orig_acc_q <= orig_next;
				dec_acc_q  <= dec_next;
				count_q    <= count_next;
				if (inner_inc >= inner_ext) begin
					inner_q <= '0;
					if (middle_inc >= middle_ext) begin
						middle_q <= '0;
						outer_q  <= outer_q + 1'b1;
					end else begin
						middle_q <= middle_inc[AW-1:0];
					end
				end else begin
					inner_q <= inner_inc[AW-1:0];
				end
			end
		end
	end

endmodule

FILE: hw/rtl/rbsm_div.sv
// Bit-serial restoring divider: signed sum by unsigned count, one quotient bit per cycle.
// No package dependencies; clamps the quotient to the sample range.
module rbsm_div #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int AXIS_WIDTH   = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [((SAMPLE_WIDTH + 3*AXIS_WIDTH > 63) ? 63
		: SAMPLE_WIDTH + 3*AXIS_WIDTH)-1:0]       dividend,
	input  logic [3*AXIS_WIDTH:0]                 divisor,
	output logic                                  busy,
	output logic signed [SAMPLE_WIDTH-1:0]        mean
);
	localparam int SUM_W   = (SAMPLE_WIDTH + 3*AXIS_WIDTH > 63) ? 63
		: SAMPLE_WIDTH + 3*AXIS_WIDTH;
	localparam int COUNT_W = 3*AXIS_WIDTH + 1;
	localparam int CNT_W   = $clog2(SUM_W + 1);
	localparam int SW      = SAMPLE_WIDTH;

	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   quo_q;
	logic [COUNT_W-1:0] rem_q, den_q;
	logic               neg_q, zero_q;

	logic [COUNT_W:0]   trial, diff;
	logic               ge;
	logic [SUM_W-1:0]   mag;

	assign busy  = (cnt_q != '0);
	assign mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(SUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= mag;
			rem_q  <= '0;
			den_q  <= divisor;
			neg_q  <= dividend[SUM_W-1];
			zero_q <= (divisor == '0);
		end else if (busy) begin
			rem_q <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	always_comb begin
		if (zero_q) begin
			mean = '0;
		end else if (quo_q[SUM_W-1:SW-1] != '0) begin
			mean = neg_q ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			mean = neg_q ? (~quo_q[SW-1:0] + 1'b1) : quo_q[SW-1:0];
		end
	end

endmodule

FILE: hw/rtl/rbsm_back.sv
// Back part: takes a record from the middle queue, runs both divisions, holds the result.
// Depends on rbsm_div; result register drives the output queue ports.
module rbsm_back #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int AXIS_WIDTH   = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  rec_empty,
	input  logic [((SAMPLE_WIDTH + 3*AXIS_WIDTH > 63) ? 63 : SAMPLE_WIDTH + 3*AXIS_WIDTH)*2
		+ 3*AXIS_WIDTH:0]                         rec_data,
	output logic                                  rec_pop,
	input  logic                                  pop,
	output logic                                  empty,
	output logic signed [((SAMPLE_WIDTH + 3*AXIS_WIDTH > 63) ? 63
		: SAMPLE_WIDTH + 3*AXIS_WIDTH)-1:0]       original_total,
	output logic signed [((SAMPLE_WIDTH + 3*AXIS_WIDTH > 63) ? 63
		: SAMPLE_WIDTH + 3*AXIS_WIDTH)-1:0]       decoded_total,
	output logic signed [SAMPLE_WIDTH-1:0]        original_mean,
	output logic signed [SAMPLE_WIDTH-1:0]        decoded_mean,
	output logic [3*AXIS_WIDTH:0]                 element_count
);
	localparam int SUM_W   = (SAMPLE_WIDTH + 3*AXIS_WIDTH > 63) ? 63
		: SAMPLE_WIDTH + 3*AXIS_WIDTH;
	localparam int COUNT_W = 3*AXIS_WIDTH + 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic                      state_q;
	logic signed [SUM_W-1:0]   orig_total_q, dec_total_q;
	logic [COUNT_W-1:0]        count_q;
	logic                      out_valid_q;
	logic signed [SUM_W-1:0]   rec_orig, rec_dec;
	logic [COUNT_W-1:0]        rec_count;
	logic                      busy_orig, busy_dec;
	logic signed [SAMPLE_WIDTH-1:0] mean_orig, mean_dec;
	logic                      out_free, load_out;

	assign {rec_orig, rec_dec, rec_count} = rec_data;

	assign rec_pop  = (state_q == ST_IDLE) && !rec_empty;
	assign out_free = !out_valid_q || pop;
	assign load_out = (state_q == ST_DIV) && !busy_orig && !busy_dec && out_free;
	assign empty    = !out_valid_q;

	rbsm_div #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.AXIS_WIDTH  (AXIS_WIDTH)
	) u_div_orig (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rec_pop),
		.dividend(rec_orig),
		.divisor (rec_count),
		.busy    (busy_orig),
		.mean    (mean_orig)
	);

	rbsm_div #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.AXIS_WIDTH  (AXIS_WIDTH)
	) u_div_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rec_pop),
		.dividend(rec_dec),
		.divisor (rec_count),
		.busy    (busy_dec),
		.mean    (mean_dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rec_pop) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			orig_total_q <= rec_orig;
			dec_total_q  <= rec_dec;
			count_q      <= rec_count;
		end
		if (load_out) begin
			original_total <= orig_total_q;
			decoded_total  <= dec_total_q;
			element_count  <= count_q;
			original_mean  <= mean_orig;
			decoded_mean   <= mean_dec;
		end
	end

endmodule

FILE: hw/rtl/region_box_sum_and_mean.sv
// Top level of the region box sum and mean block.
// Depends on rbsm_pkg, rbsm_front, rbsm_fifo, rbsm_back.
//
//   channel   handshake            payload
//   input     push / full          original_sample, decoded_sample, last_element
//   result    empty / pop          original_total, decoded_total, original_mean,
//                                  decoded_mean, element_count
//   config    cfg_we               cfg_index, cfg_data
//
// One input transaction per cycle while the middle queue has room.
// A result is set by the bit-serial dividers, which work through the SUM_W-bit sums
// (SUM_W = 52 at the default widths); the back takes no new array until it has loaded the last result.
// full rises only when two finished arrays wait in the middle queue; the input then stalls.
// Reset clears indices, sums, queues and configuration registers; no clearing pass is needed.
module region_box_sum_and_mean #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int AXIS_WIDTH   = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  rbsm_pkg::cfg_index_t                  cfg_index,
	input  logic [AXIS_WIDTH:0]                   cfg_data,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [SAMPLE_WIDTH-1:0]        original_sample,
	input  logic signed [SAMPLE_WIDTH-1:0]        decoded_sample,
	input  logic                                  last_element,
	input  logic                                  pop,
	output logic                                  empty,
	output logic signed [((SAMPLE_WIDTH + 3*AXIS_WIDTH > 63) ? 63
		: SAMPLE_WIDTH + 3*AXIS_WIDTH)-1:0]       original_total,
	output logic signed [((SAMPLE_WIDTH + 3*AXIS_WIDTH > 63) ? 63
		: SAMPLE_WIDTH + 3*AXIS_WIDTH)-1:0]       decoded_total,
	output logic signed [SAMPLE_WIDTH-1:0]        original_mean,
	output logic signed [SAMPLE_WIDTH-1:0]        decoded_mean,
	output logic [3*AXIS_WIDTH:0]                 element_count
);
	import rbsm_pkg::*;

	localparam int SUM_W   = (SAMPLE_WIDTH + 3*AXIS_WIDTH > 63) ? 63
		: SAMPLE_WIDTH + 3*AXIS_WIDTH;
	localparam int COUNT_W = 3*AXIS_WIDTH + 1;
	localparam int REC_W   = 2*SUM_W + COUNT_W;

	logic             accept;
	logic             rec_push, rec_pop, rec_empty;
	logic [REC_W-1:0] rec_wdata, rec_rdata;

	assign accept = push && !full;

	rbsm_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.AXIS_WIDTH  (AXIS_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.accept         (accept),
		.original_sample(original_sample),
		.decoded_sample (decoded_sample),
		.last_element   (last_element),
		.rec_push       (rec_push),
		.rec_data       (rec_wdata)
	);

	rbsm_fifo #(
		.WIDTH(REC_W),
		.DEPTH(2)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rec_push),
		.wdata (rec_wdata),
		.full  (full),
		.pop   (rec_pop),
		.rdata (rec_rdata),
		.empty (rec_empty)
	);

	rbsm_back #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.AXIS_WIDTH  (AXIS_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_empty     (rec_empty),
		.rec_data      (rec_rdata),
		.rec_pop       (rec_pop),
		.pop           (pop),
		.empty         (empty),
		.original_total(original_total),
		.decoded_total (decoded_total),
		.original_mean (original_mean),
		.decoded_mean  (decoded_mean),
		.element_count (element_count)
	);

endmodule

FILE: test/tb_region_box_sum_and_mean.sv
// Testbench for region_box_sum_and_mean: streams sample pairs, predicts each region
// summary, and checks every result in order. Depends on rbsm_pkg and the block's RTL.
module tb_region_box_sum_and_mean;
	import rbsm_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int SAMPLE_W       = 16;
	localparam int AXIS_W         = 12;
	localparam int SUM_W          = SAMPLE_W + 3 * AXIS_W;
	localparam int COUNT_W        = 3 * AXIS_W + 1;
	localparam int AXIS_SPAN      = 1 << AXIS_W;
	localparam int NUM_REGS       = 8;
	localparam int DRAIN_CYCLES   = SUM_W + 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;

	typedef logic [AXIS_W:0] box_regs_t [NUM_REGS];

	typedef struct packed {
		logic signed [SUM_W-1:0]    original_total;
		logic signed [SUM_W-1:0]    decoded_total;
		logic signed [SAMPLE_W-1:0] original_mean;
		logic signed [SAMPLE_W-1:0] decoded_mean;
		logic [COUNT_W-1:0]         element_count;
	} region_summary_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	cfg_index_t                 cfg_index = REG_MIDDLE_SIZE;
	logic [AXIS_W:0]            cfg_data = '0;
	logic                       push = 1'b0;
	logic                       full;
	logic signed [SAMPLE_W-1:0] original_sample = '0;
	logic signed [SAMPLE_W-1:0] decoded_sample = '0;
	logic                       last_element = 1'b0;
	logic                       pop = 1'b0;
	logic                       empty;
	logic signed [SUM_W-1:0]    original_total;
	logic signed [SUM_W-1:0]    decoded_total;
	logic signed [SAMPLE_W-1:0] original_mean;
	logic signed [SAMPLE_W-1:0] decoded_mean;
	logic [COUNT_W-1:0]         element_count;

	box_regs_t box_cfg = '{13'd1, 13'd1, 13'd0, 13'd0, 13'd0, 13'd4096, 13'd4096, 13'd4096};
	logic [AXIS_W-1:0] outer_pos = '0;
	logic [AXIS_W-1:0] middle_pos = '0;
	logic [AXIS_W-1:0] inner_pos = '0;
	longint            original_sum = 0;
	longint            decoded_sum = 0;
	longint unsigned   inside_total = 0;

	region_summary_t expected_summaries[$];
	int              mismatches = 0;
	int              quiet_cycles = 0;
	int              send_idle_pct = 0;
	int              pop_stall_pct = 0;

	region_box_sum_and_mean uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.original_sample(original_sample),
		.decoded_sample(decoded_sample),
		.last_element(last_element),
		.pop(pop),
		.empty(empty),
		.original_total(original_total),
		.decoded_total(decoded_total),
		.original_mean(original_mean),
		.decoded_mean(decoded_mean),
		.element_count(element_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic longint clip_sum(longint v);
		longint top;
		top = (longint'(1) <<< (SUM_W - 1)) - 1;
		if (v > top)
			return top;
		if (v < -top - 1)
			return -top - 1;
		return v;
	endfunction

	function automatic logic [SAMPLE_W-1:0] truncated_mean(longint total, longint unsigned n);
		longint q;
		longint top;
		top = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
		if (n == 0)
			return '0;
		q = total / longint'(n);
		if (q > top)
			q = top;
		if (q < -top - 1)
			q = -top - 1;
		return q[SAMPLE_W-1:0];
	endfunction

	function automatic int axis_extent(logic [AXIS_W:0] size);
		if (size == 0)
			return 1;
		if (size > AXIS_SPAN)
			return AXIS_SPAN;
		return int'(size);
	endfunction

	function automatic void accumulate_sample(logic [SAMPLE_W-1:0] orig,
			logic [SAMPLE_W-1:0] dec, logic last);
		region_summary_t s;
		bit              in_box;
		in_box = outer_pos >= box_cfg[REG_OUTER_BEGIN] && outer_pos < box_cfg[REG_OUTER_LIMIT] &&
			middle_pos >= box_cfg[REG_MIDDLE_BEGIN] && middle_pos < box_cfg[REG_MIDDLE_LIMIT] &&
			inner_pos >= box_cfg[REG_INNER_BEGIN] && inner_pos < box_cfg[REG_INNER_LIMIT];
		if (in_box) begin
			original_sum = clip_sum(original_sum + longint'($signed(orig)));
			decoded_sum = clip_sum(decoded_sum + longint'($signed(dec)));
			if (inside_total < (64'd1 << COUNT_W) - 1)
				inside_total++;
		end
		if (last) begin
			s.original_total = original_sum[SUM_W-1:0];
			s.decoded_total = decoded_sum[SUM_W-1:0];
			s.original_mean = truncated_mean(original_sum, inside_total);
			s.decoded_mean = truncated_mean(decoded_sum, inside_total);
			s.element_count = inside_total[COUNT_W-1:0];
			expected_summaries.push_back(s);
			outer_pos = '0;
			middle_pos = '0;
			inner_pos = '0;
			original_sum = 0;
			decoded_sum = 0;
			inside_total = 0;
		end else if (int'(inner_pos) + 1 >= axis_extent(box_cfg[REG_INNER_SIZE])) begin
			inner_pos = '0;
			if (int'(middle_pos) + 1 >= axis_extent(box_cfg[REG_MIDDLE_SIZE])) begin
				middle_pos = '0;
				outer_pos = outer_pos + 1'b1;
			end else begin
				middle_pos = middle_pos + 1'b1;
			end
		end else begin
			inner_pos = inner_pos + 1'b1;
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] draw_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	function automatic logic [AXIS_W:0] draw_extent();
		case ($urandom_range(7))
			0: return 13'd0;
			1: return 13'd4096;
			2: return (AXIS_W+1)'($urandom_range(8191, 4097));
			default: return (AXIS_W+1)'($urandom_range(5, 1));
		endcase
	endfunction

	function automatic void draw_window(input int span, output logic [AXIS_W:0] first,
			output logic [AXIS_W:0] past);
		int lo;
		lo = $urandom_range(span, 0);
		case ($urandom_range(9))
			0: begin
				first = 13'd0;
				past = 13'd4096;
			end
			1: begin
				first = 13'd4095;
				past = 13'd4096;
			end
			2: begin
				first = (AXIS_W+1)'(lo + AXIS_SPAN);
				past = (AXIS_W+1)'($urandom_range(AXIS_SPAN, 0));
			end
			3: begin
				first = (AXIS_W+1)'(lo);
				past = (AXIS_W+1)'(lo);
			end
			4: begin
				first = (AXIS_W+1)'(lo + 1);
				past = (AXIS_W+1)'(lo);
			end
			default: begin
				first = (AXIS_W+1)'(lo);
				past = (AXIS_W+1)'($urandom_range(span + 2, lo + 1));
			end
		endcase
	endfunction

	function automatic box_regs_t draw_box();
		box_regs_t r;
		r[REG_MIDDLE_SIZE] = draw_extent();
		r[REG_INNER_SIZE] = draw_extent();
		draw_window(3, r[REG_OUTER_BEGIN], r[REG_OUTER_LIMIT]);
		draw_window(5, r[REG_MIDDLE_BEGIN], r[REG_MIDDLE_LIMIT]);
		draw_window(5, r[REG_INNER_BEGIN], r[REG_INNER_LIMIT]);
		return r;
	endfunction

	task automatic push_sample(input logic [SAMPLE_W-1:0] orig, input logic [SAMPLE_W-1:0] dec,
			input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		original_sample <= orig;
		decoded_sample <= dec;
		last_element <= last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		accumulate_sample(orig, dec, last);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (expected_summaries.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_box(input box_regs_t regs);
		cfg_index_t idx;
		for (int i = 0; i < NUM_REGS; i++) begin
			idx = cfg_index_t'(i);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= regs[i];
			@(posedge clk);
			case (idx)
				REG_OUTER_BEGIN, REG_MIDDLE_BEGIN, REG_INNER_BEGIN:
					box_cfg[i] = {1'b0, regs[i][AXIS_W-1:0]};
				default:
					box_cfg[i] = regs[i];
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_window();
		push_sample(16'h7fff, 16'h8000, 1'b1);
		push_sample(16'h8000, 16'h7fff, 1'b0);
		push_sample(16'h8000, 16'h7fff, 1'b0);
		push_sample(16'hffff, 16'h0001, 1'b1);
	endtask

	task automatic test_partial_box();
		box_regs_t r;
		drain_results();
		r = box_cfg;
		r[REG_MIDDLE_SIZE] = 13'd2;
		r[REG_INNER_SIZE] = 13'd3;
		r[REG_OUTER_BEGIN] = 13'd1;
		r[REG_MIDDLE_BEGIN] = 13'd1;
		r[REG_INNER_BEGIN] = 13'd1;
		r[REG_OUTER_LIMIT] = 13'd4096;
		r[REG_MIDDLE_LIMIT] = 13'd4096;
		r[REG_INNER_LIMIT] = 13'd3;
		load_box(r);
		for (int i = 0; i < 12; i++)
			push_sample(i[0] ? 16'h7fff : 16'h8000, draw_sample(), i == 11);
	endtask

	task automatic test_empty_box();
		box_regs_t r;
		drain_results();
		r = box_cfg;
		r[REG_MIDDLE_SIZE] = 13'd1;
		r[REG_INNER_SIZE] = 13'd1;
		r[REG_OUTER_BEGIN] = 13'd5;
		r[REG_OUTER_LIMIT] = 13'd5;
		load_box(r);
		for (int i = 0; i < 3; i++)
			push_sample(draw_sample(), draw_sample(), i == 2);
		drain_results();
		r[REG_OUTER_BEGIN] = 13'd0;
		r[REG_OUTER_LIMIT] = 13'd4096;
		r[REG_INNER_BEGIN] = 13'd3;
		r[REG_INNER_LIMIT] = 13'd1;
		load_box(r);
		push_sample(draw_sample(), draw_sample(), 1'b0);
		push_sample(draw_sample(), draw_sample(), 1'b1);
	endtask

	task automatic test_resize_mid_array();
		box_regs_t r;
		drain_results();
		r = box_cfg;
		r[REG_MIDDLE_SIZE] = 13'd1;
		r[REG_INNER_SIZE] = 13'd5;
		r[REG_OUTER_BEGIN] = 13'd0;
		r[REG_MIDDLE_BEGIN] = 13'd0;
		r[REG_INNER_BEGIN] = 13'd0;
		r[REG_OUTER_LIMIT] = 13'd4096;
		r[REG_MIDDLE_LIMIT] = 13'd4096;
		r[REG_INNER_LIMIT] = 13'd4;
		load_box(r);
		for (int i = 0; i < 4; i++)
			push_sample(draw_sample(), draw_sample(), 1'b0);
		drain_results();
		r[REG_INNER_SIZE] = 13'd2;
		load_box(r);
		for (int i = 0; i < 3; i++)
			push_sample(draw_sample(), draw_sample(), i == 2);
	endtask

	task automatic test_extent_clamp();
		box_regs_t r;
		drain_results();
		r[REG_MIDDLE_SIZE] = 13'd0;
		r[REG_INNER_SIZE] = 13'd8191;
		r[REG_OUTER_BEGIN] = 13'h1000;
		r[REG_MIDDLE_BEGIN] = 13'h1000;
		r[REG_INNER_BEGIN] = 13'd0;
		r[REG_OUTER_LIMIT] = 13'd2;
		r[REG_MIDDLE_LIMIT] = 13'd4096;
		r[REG_INNER_LIMIT] = 13'd2;
		load_box(r);
		for (int i = 0; i < 10; i++)
			push_sample(draw_sample(), draw_sample(), i == 9);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
		int until_reload;
		drain_results();
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		load_box(draw_box());
		until_reload = $urandom_range(60, 15);
		for (int i = 0; i < n_items; i++) begin
			push_sample(draw_sample(), draw_sample(), $urandom_range(9) == 0);
			until_reload--;
			if (until_reload == 0) begin
				drain_results();
				load_box(draw_box());
				until_reload = $urandom_range(60, 15);
			end
		end
	endtask

	always @(posedge clk)
		pop <= ($urandom_range(99) >= pop_stall_pct);

	always @(posedge clk) begin : check_results
		region_summary_t got;
		region_summary_t want;
		if (arst_n && pop && !empty) begin
			got.original_total = original_total;
			got.decoded_total = decoded_total;
			got.original_mean = original_mean;
			got.decoded_mean = decoded_mean;
			got.element_count = element_count;
			if (expected_summaries.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: totals %0d %0d means %0d %0d count %0d",
						got.original_total, got.decoded_total, got.original_mean,
						got.decoded_mean, got.element_count);
			end else begin
				want = expected_summaries.pop_front();
				if (got.original_total !== want.original_total ||
						got.decoded_total !== want.decoded_total ||
						got.original_mean !== want.original_mean ||
						got.decoded_mean !== want.decoded_mean ||
						got.element_count !== want.element_count) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch at %0t: want %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
							$realtime, want.original_total, want.decoded_total,
							want.original_mean, want.decoded_mean, want.element_count,
							got.original_total, got.decoded_total, got.original_mean,
							got.decoded_mean, got.element_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_window();
		test_partial_box();
		test_empty_box();
		test_resize_mid_array();
		test_extent_clamp();
		test_random_traffic(0, 0, 150);
		test_random_traffic(55, 0, 150);
		test_random_traffic(0, 55, 150);
		test_random_traffic(18, 18, 150);
		drain_results();
		if (mismatches == 0 && expected_summaries.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/rbsm_pkg.sv
hw/rtl/rbsm_fifo.sv
hw/rtl/rbsm_front.sv
hw/rtl/rbsm_div.sv
hw/rtl/rbsm_back.sv
hw/rtl/region_box_sum_and_mean.sv
test/tb_region_box_sum_and_mean.sv
